// ===== sv/vdrp_pkg.sv =====
// shared types, constants and tables for the vcxo divider and rfreq programmer
// no dependencies
package vdrp_pkg;

   localparam int RX_W    = 26;
   localparam int OSC_W   = 28;
   localparam int XTAL_W  = 31;
   localparam int RFREQ_W = 38;
   localparam int NUM_W   = 66;
   localparam int DEN_W   = 31;
   localparam int MUL_A_W = 38;
   localparam int MUL_B_W = 28;
   localparam int D_W     = 11;
   localparam int HS_N    = 6;
   localparam int HS_IDX_W = 3;
   localparam int RECIP_SH = 18;
   localparam int RECIP_W  = 17;

   localparam logic [XTAL_W-1:0]  XTAL_RESET     = 31'd1828464322;
   localparam logic [OSC_W-1:0]   STARTUP_OSC_HZ = 28'd56320000;
   localparam logic [OSC_W-1:0]   FOUT_MIN_HZ    = 28'd10000000;
   localparam logic [NUM_W-1:0]   FDCO_MIN_M1    = 66'd4849999999;
   localparam logic [NUM_W-1:0]   FDCO_MAX_HZ    = 66'd5670000000;
   localparam logic [RFREQ_W-1:0] D_CAP          = 38'd1408;
   localparam logic [9:0]         N1_MAX         = 10'd128;
   localparam logic [10:0]        PPM_LHS_K      = 11'd2000;
   localparam logic [2:0]         PPM_RHS_K      = 3'd7;

   // csr register indexes, taken from paddr[4:3]
   localparam logic [1:0] REG_XTAL    = 2'd0;
   localparam logic [1:0] REG_SMOOTH  = 2'd1;
   localparam logic [1:0] REG_STARTUP = 2'd2;

   // high-speed divisors in search order, with reciprocals for exact small quotients
   localparam logic [3:0] HS_TABLE [HS_N] = '{4'd11, 4'd9, 4'd7, 4'd6, 4'd5, 4'd4};
   localparam logic [RECIP_W-1:0] HS_RECIP [HS_N] = '{
      17'((1 << RECIP_SH) / 11 + 1), 17'((1 << RECIP_SH) / 9 + 1),
      17'((1 << RECIP_SH) / 7 + 1),  17'((1 << RECIP_SH) / 6 + 1),
      17'((1 << RECIP_SH) / 5 + 1),  17'((1 << RECIP_SH) / 4 + 1)};

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

// ===== sv/vdrp_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle
// depends on vdrp_pkg
module vdrp_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [vdrp_pkg::MUL_A_W-1:0]      op_a,
   input  logic [vdrp_pkg::MUL_B_W-1:0]      op_b,
   output logic [vdrp_pkg::NUM_W-1:0]        product,
   output vdrp_pkg::unit_stat_type           stat
);
   logic [vdrp_pkg::NUM_W-1:0]   a_ff, a_in, acc_ff, acc_in;
   logic [vdrp_pkg::MUL_B_W-1:0] b_ff, b_in;
   logic [4:0]                   cnt_ff, cnt_in;
   logic                         busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = vdrp_pkg::NUM_W'(op_a);
         b_in = op_b;
         acc_in = '0;
         cnt_in = 5'(vdrp_pkg::MUL_B_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) acc_in = acc_ff + a_ff;
         a_in = {a_ff[vdrp_pkg::NUM_W-2:0], 1'b0};
         b_in = {1'b0, b_ff[vdrp_pkg::MUL_B_W-1:1]};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
   end

   assign product = acc_ff;
   assign stat = '{busy: busy_ff, done: done_ff};
endmodule

// ===== sv/vdrp_div.sv =====
// restoring divider, one quotient bit per cycle, quotient saturated to 38 bits
// depends on vdrp_pkg
module vdrp_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [vdrp_pkg::NUM_W-1:0]        num,
   input  logic [vdrp_pkg::DEN_W-1:0]        den,
   output logic [vdrp_pkg::RFREQ_W-1:0]      quot,
   output vdrp_pkg::unit_stat_type           stat
);
   logic [vdrp_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [vdrp_pkg::DEN_W-1:0]   den_ff, den_in, rem_ff, rem_in;
   logic [vdrp_pkg::RFREQ_W-1:0] q_ff, q_in;
   logic                         ovf_ff, ovf_in;
   logic [6:0]                   cnt_ff, cnt_in;
   logic                         busy_ff, busy_in, done_ff, done_in;
   logic [vdrp_pkg::DEN_W:0]     rem_sh, rem_sub;
   logic                         qbit;

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      ovf_in = ovf_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh = {rem_ff, num_ff[vdrp_pkg::NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      qbit = (rem_sh >= {1'b0, den_ff});
      if (start) begin
         num_in = num;
         den_in = den;
         rem_in = '0;
         q_in = '0;
         ovf_in = 1'b0;
         cnt_in = 7'(vdrp_pkg::NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? rem_sub[vdrp_pkg::DEN_W-1:0] : rem_sh[vdrp_pkg::DEN_W-1:0];
         num_in = {num_ff[vdrp_pkg::NUM_W-2:0], 1'b0};
         q_in = {q_ff[vdrp_pkg::RFREQ_W-2:0], qbit};
         // a one shifted out of the top means the quotient is past 38 bits
         ovf_in = ovf_ff | q_ff[vdrp_pkg::RFREQ_W-1];
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      ovf_ff <= ovf_in;
   end

   assign quot = ovf_ff ? '1 : q_ff;
   assign stat = '{busy: busy_ff, done: done_ff};
endmodule

// ===== sv/vcxo_divider_and_rfreq_programmer.sv =====
// top level: csr port, sequencer, divider search and register byte packing
// depends on vdrp_pkg, vdrp_mul, vdrp_div
//
// smooth path: one multiply of 28 steps and one divide of 66 steps;
// full path: two divides for the divider bounds, the search, then a multiply and a divide,
// the search trying one divisor per cycle
// throughput: one transaction in flight, req_tready high only when idle
// reset: synchronous, restores the register defaults and the startup oscillator state
module vcxo_divider_and_rfreq_programmer (
   input  logic        clock,
   input  logic        reset,
   // request: rx_freq_hz [25:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // response: hs_n1_byte [7:0], n1_rfreq_byte [15:8], rfreq_mid_byte [23:16],
   // frac_byte_hi [31:24], frac_byte_mid [39:32], frac_byte_lo [47:40],
   // post_divider [53:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   // response flags: smooth_write [0], search_failed [1]
   output logic [1:0]  rsp_tuser,
   // apb-style csr port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SMCHK  = 4'd1;
   localparam logic [3:0] ST_RS_MUL = 4'd2;
   localparam logic [3:0] ST_RS_DIV = 4'd3;
   localparam logic [3:0] ST_DMIN   = 4'd4;
   localparam logic [3:0] ST_DMAX   = 4'd5;
   localparam logic [3:0] ST_SEARCH = 4'd6;
   localparam logic [3:0] ST_P_MUL  = 4'd7;
   localparam logic [3:0] ST_P_DIV  = 4'd8;
   localparam logic [3:0] ST_FINISH = 4'd9;

   // configuration and persistent state
   logic [vdrp_pkg::XTAL_W-1:0]  xtal_ff, xtal_in;
   logic                         smooth_en_ff, smooth_en_in;
   logic [vdrp_pkg::RFREQ_W-1:0] startup_ff, startup_in;
   logic [vdrp_pkg::OSC_W-1:0]   cur_osc_ff, cur_osc_in;
   logic [vdrp_pkg::RFREQ_W-1:0] rfreq_val_ff, rfreq_val_in;

   // per-transaction working registers
   logic [3:0]                   state_ff, state_in;
   logic [vdrp_pkg::OSC_W-1:0]   f_ff, f_in;
   logic [5:0]                   pd_ff, pd_in;
   logic                         smooth_ff, smooth_in, failed_ff, failed_in;
   logic [vdrp_pkg::D_W-1:0]     d_ff, d_in, dmax_ff, dmax_in;
   logic [vdrp_pkg::HS_IDX_W-1:0] k_ff, k_in;
   logic [3:0]                   hs_ff, hs_in;
   logic [7:0]                   n1_ff, n1_in;
   logic [vdrp_pkg::RFREQ_W-1:0] r_ff, r_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [55:0]                  rsp_data_ff, rsp_data_in;
   logic [1:0]                   rsp_user_ff, rsp_user_in;

   // shared units
   logic                         mul_start, div_start;
   logic [vdrp_pkg::MUL_A_W-1:0] mul_a;
   logic [vdrp_pkg::MUL_B_W-1:0] mul_b;
   logic [vdrp_pkg::NUM_W-1:0]   mul_p, div_num;
   logic [vdrp_pkg::DEN_W-1:0]   div_den;
   logic [vdrp_pkg::RFREQ_W-1:0] div_q;
   vdrp_pkg::unit_stat_type      mul_stat, div_stat;

   // combinational helpers
   logic [vdrp_pkg::OSC_W-1:0]   f_w;
   logic [5:0]                   pd_w;
   logic [vdrp_pkg::OSC_W-1:0]   diff_w;
   logic [38:0]                  ppm_lhs, ppm_rhs;
   logic                         smooth_hit;
   logic [3:0]                   h_w;
   logic [27:0]                  recip_p;
   logic [9:0]                   q_w;
   logic [13:0]                  rem_w;
   logic                         hit_w;
   logic [vdrp_pkg::RFREQ_W-1:0] dmin_w, dmax_w;
   logic [6:0]                   n1code;
   logic [2:0]                   hs_code;
   logic [9:0]                   whole;
   logic [27:0]                  frac;
   logic                         csr_wr;

   vdrp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p),
      .stat    (mul_stat)
   );

   vdrp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (div_q),
      .stat  (div_stat)
   );

   // oscillator frequency is 4x rx; postdivider doubles up to 32 while below 10 MHz
   always_comb begin
      f_w = {req_tdata[vdrp_pkg::RX_W-1:0], 2'b00};
      pd_w = 6'd1;
      for (int i = 0; i < 5; i++) begin
         if (f_w < vdrp_pkg::FOUT_MIN_HZ) begin
            f_w = {f_w[vdrp_pkg::OSC_W-2:0], 1'b0};
            pd_w = {pd_w[4:0], 1'b0};
         end
      end
   end

   // 3500 ppm window, both sides divided by 500
   always_comb begin
      diff_w = (f_ff > cur_osc_ff) ? (f_ff - cur_osc_ff) : (cur_osc_ff - f_ff);
      ppm_lhs = 39'(diff_w) * 39'(vdrp_pkg::PPM_LHS_K);
      ppm_rhs = 39'(cur_osc_ff) * 39'(vdrp_pkg::PPM_RHS_K);
      smooth_hit = smooth_en_ff && (cur_osc_ff != '0) && (ppm_lhs < ppm_rhs);
   end

   // one divisor per cycle: exact d / hs by reciprocal, then check remainder and n1
   always_comb begin
      h_w = vdrp_pkg::HS_TABLE[k_ff];
      recip_p = 28'(d_ff) * 28'(vdrp_pkg::HS_RECIP[k_ff]);
      q_w = recip_p[27:vdrp_pkg::RECIP_SH];
      rem_w = 14'(d_ff) - 14'(q_w) * 14'(h_w);
      hit_w = (rem_w == '0) && ((q_w == 10'd1) || !q_w[0]) && (q_w <= vdrp_pkg::N1_MAX);
   end

   assign dmin_w = div_q + 38'd1;
   assign dmax_w = (div_q > vdrp_pkg::D_CAP) ? vdrp_pkg::D_CAP : div_q;

   // register byte packing
   always_comb begin
      n1code = 7'(n1_ff - 8'd1);
      hs_code = 3'(hs_ff - 4'd4);
      if (smooth_ff) begin
         n1code = '0;
         hs_code = '0;
      end
      whole = r_ff[37:28];
      frac = r_ff[27:0];
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      state_in = state_ff;
      f_in = f_ff;
      pd_in = pd_ff;
      smooth_in = smooth_ff;
      failed_in = failed_ff;
      d_in = d_ff;
      dmax_in = dmax_ff;
      k_in = k_ff;
      hs_in = hs_ff;
      n1_in = n1_ff;
      r_in = r_ff;
      cur_osc_in = cur_osc_ff;
      rfreq_val_in = rfreq_val_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      xtal_in = xtal_ff;
      smooth_en_in = smooth_en_ff;
      startup_in = startup_ff;
      mul_start = 1'b0;
      mul_a = rfreq_val_ff;
      mul_b = f_ff;
      div_start = 1'b0;
      div_num = vdrp_pkg::FDCO_MIN_M1;
      div_den = vdrp_pkg::DEN_W'(f_ff);

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               f_in = f_w;
               pd_in = pd_w;
               smooth_in = 1'b0;
               failed_in = 1'b0;
               state_in = ST_SMCHK;
            end
         end
         ST_SMCHK: begin
            if (smooth_hit) begin
               smooth_in = 1'b1;
               mul_start = 1'b1;
               state_in = ST_RS_MUL;
            end else if ((f_ff == '0) || (xtal_ff == '0)) begin
               failed_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               div_start = 1'b1;
               state_in = ST_DMIN;
            end
         end
         ST_RS_MUL: begin
            if (mul_stat.done) begin
               div_start = 1'b1;
               div_num = mul_p;
               div_den = vdrp_pkg::DEN_W'(cur_osc_ff);
               state_in = ST_RS_DIV;
            end
         end
         ST_RS_DIV: begin
            if (div_stat.done) begin
               r_in = div_q;
               state_in = ST_FINISH;
            end
         end
         ST_DMIN: begin
            if (div_stat.done) begin
               if (dmin_w > vdrp_pkg::D_CAP) begin
                  failed_in = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  d_in = dmin_w[vdrp_pkg::D_W-1:0];
                  div_start = 1'b1;
                  div_num = vdrp_pkg::FDCO_MAX_HZ;
                  state_in = ST_DMAX;
               end
            end
         end
         ST_DMAX: begin
            if (div_stat.done) begin
               if (38'(d_ff) > dmax_w) begin
                  failed_in = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  dmax_in = dmax_w[vdrp_pkg::D_W-1:0];
                  k_in = '0;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (hit_w) begin
               hs_in = h_w;
               n1_in = q_w[7:0];
               mul_start = 1'b1;
               mul_a = vdrp_pkg::MUL_A_W'(f_ff);
               mul_b = vdrp_pkg::MUL_B_W'(d_ff);
               state_in = ST_P_MUL;
            end else if (k_ff == vdrp_pkg::HS_IDX_W'(vdrp_pkg::HS_N - 1)) begin
               if (d_ff == dmax_ff) begin
                  failed_in = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  d_in = d_ff + 11'd1;
                  k_in = '0;
               end
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         ST_P_MUL: begin
            if (mul_stat.done) begin
               // f * d stays below 2^34, scaled by 2^32 before dividing by the 1/16 Hz crystal
               div_start = 1'b1;
               div_num = {mul_p[33:0], 32'd0};
               div_den = xtal_ff;
               state_in = ST_P_DIV;
            end
         end
         ST_P_DIV: begin
            if (div_stat.done) begin
               r_in = div_q;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in = {failed_ff, smooth_ff};
               if (failed_ff) begin
                  rsp_data_in = {2'b00, pd_ff, 48'd0};
               end else begin
                  rsp_data_in = {2'b00, pd_ff, frac[7:0], frac[15:8], frac[23:16],
                                 whole[3:0], frac[27:24], n1code[1:0], whole[9:4],
                                 hs_code, n1code[6:2]};
                  cur_osc_in = f_ff;
                  rfreq_val_in = r_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_wr) begin
         case (csr_paddr[4:3])
            vdrp_pkg::REG_XTAL:   xtal_in = csr_pwdata[vdrp_pkg::XTAL_W-1:0];
            vdrp_pkg::REG_SMOOTH: smooth_en_in = csr_pwdata[0];
            vdrp_pkg::REG_STARTUP: begin
               startup_in = csr_pwdata[vdrp_pkg::RFREQ_W-1:0];
               rfreq_val_in = csr_pwdata[vdrp_pkg::RFREQ_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:3])
         vdrp_pkg::REG_XTAL:    csr_prdata = 64'(xtal_ff);
         vdrp_pkg::REG_SMOOTH:  csr_prdata = 64'(smooth_en_ff);
         vdrp_pkg::REG_STARTUP: csr_prdata = 64'(startup_ff);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         xtal_ff <= vdrp_pkg::XTAL_RESET;
         smooth_en_ff <= 1'b0;
         startup_ff <= '0;
         cur_osc_ff <= vdrp_pkg::STARTUP_OSC_HZ;
         rfreq_val_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         xtal_ff <= xtal_in;
         smooth_en_ff <= smooth_en_in;
         startup_ff <= startup_in;
         cur_osc_ff <= cur_osc_in;
         rfreq_val_ff <= rfreq_val_in;
      end
      f_ff <= f_in;
      pd_ff <= pd_in;
      smooth_ff <= smooth_in;
      failed_ff <= failed_in;
      d_ff <= d_in;
      dmax_ff <= dmax_in;
      k_ff <= k_in;
      hs_ff <= hs_in;
      n1_ff <= n1_in;
      r_ff <= r_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
   assign csr_pready = 1'b1;
endmodule
